// ===== hdl/tpsr_pkg.sv =====
// Shared types, constants and the command lookup for the touch panel SPI readout.
// Used by the controller, the datapath and the top level; depends on nothing.
package tpsr_pkg;

    // Controller command codes, one per axis, shifted out MSB first.
    localparam logic [7:0] CMD_X = 8'b11011011;
    localparam logic [7:0] CMD_Y = 8'b10011011;
    localparam logic [7:0] CMD_Z = 8'b10111011;

    // Axis codes held in the axis select register.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [7:0] HALF_RESET = 8'd4;
    localparam logic [3:0] CMD_MSB    = 4'd7;
    localparam logic [3:0] READ_BITS  = 4'd9;

    // Result scaling.
    localparam logic [7:0]  X_MAX        = 8'd240;
    localparam logic [8:0]  Y_MAX        = 9'd320;
    localparam logic [8:0]  Y_OFFSET     = 9'd15;
    localparam logic [19:0] RECIP3       = 20'd683;
    localparam int          RECIP3_SHIFT = 11;
    localparam logic [16:0] P_BIAS       = 17'd255;

    // Restoring divider for 256 / z.
    localparam logic [8:0] DIVIDEND  = 9'd256;
    localparam logic [3:0] DIV_STEPS = 4'd9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick_clr;
        logic tick_inc;
        logic begin_txn;
        logic axis_clr;
        logic axis_inc;
        logic clk_hi;
        logic clk_lo;
        logic cs_hi;
        logic bit_dec;
        logic shreg_clr;
        logic sample;
        logic store_x;
        logic store_y;
        logic calc_start;
        logic idle_fix;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       phase_done;
        logic       bit_zero;
        logic       bits_full;
        logic [1:0] axis;
        logic       div_done;
    } dp_stat_t;

    // Flags from the controller to the output stage.
    typedef struct packed {
        logic calc_active;
        logic hold_word;
        logic emit_result;
        logic busy_next;
    } ctrl_flag_t;

    // Pin levels after the current tick.
    typedef struct packed {
        logic cs_n;
        logic sclk;
        logic sdi;
    } pins_t;

    // Scaled position and pressure estimate.
    typedef struct packed {
        logic [7:0]        x_pos;
        logic [8:0]        y_pos;
        logic signed [16:0] pressure;
        logic              p_inv;
    } res_t;

    function automatic logic [7:0] cmd_code(input logic [1:0] axis);
        logic [7:0] code;
        case (axis)
            AXIS_X:  code = CMD_X;
            AXIS_Y:  code = CMD_Y;
            default: code = CMD_Z;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/tpsr_ctrl.sv =====
// Sequencer state machine for the touch panel SPI readout.
// Depends on tpsr_pkg; drives datapath commands and output-stage flags.
module tpsr_ctrl
    import tpsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       start_req,
    input  logic       out_free,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output ctrl_flag_t flags
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b00000001,
        S_CMD_LOW  = 8'b00000010,
        S_CMD_HIGH = 8'b00000100,
        S_RD_LOW   = 8'b00001000,
        S_RD_HIGH  = 8'b00010000,
        S_TAIL     = 8'b00100000,
        S_GAP      = 8'b01000000,
        S_CALC     = 8'b10000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick && start_req)
                begin
                    cmd.axis_clr  = 1'b1;
                    cmd.begin_txn = 1'b1;
                    state_next    = S_CMD_LOW;
                end
            end
            S_CMD_LOW:
            begin
                if (tick)
                begin
                    if (stat.phase_done)
                    begin
                        cmd.tick_clr = 1'b1;
                        cmd.clk_hi   = 1'b1;
                        state_next   = S_CMD_HIGH;
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                    end
                end
            end
            S_CMD_HIGH:
            begin
                if (tick)
                begin
                    if (stat.phase_done)
                    begin
                        cmd.tick_clr = 1'b1;
                        cmd.clk_lo   = 1'b1;
                        if (stat.bit_zero)
                        begin
                            cmd.shreg_clr = 1'b1;
                            state_next    = S_RD_LOW;
                        end
                        else
                        begin
                            cmd.bit_dec = 1'b1;
                            state_next  = S_CMD_LOW;
                        end
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                    end
                end
            end
            S_RD_LOW:
            begin
                if (tick)
                begin
                    if (stat.phase_done)
                    begin
                        cmd.tick_clr = 1'b1;
                        cmd.sample   = 1'b1;
                        cmd.clk_hi   = 1'b1;
                        state_next   = S_RD_HIGH;
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                    end
                end
            end
            S_RD_HIGH:
            begin
                if (tick)
                begin
                    if (stat.phase_done)
                    begin
                        cmd.tick_clr = 1'b1;
                        cmd.clk_lo   = 1'b1;
                        state_next   = stat.bits_full ? S_TAIL : S_RD_LOW;
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                    end
                end
            end
            S_TAIL:
            begin
                if (tick)
                begin
                    if (stat.phase_done)
                    begin
                        cmd.tick_clr = 1'b1;
                        cmd.cs_hi    = 1'b1;
                        case (stat.axis)
                            AXIS_X:
                            begin
                                cmd.store_x  = 1'b1;
                                cmd.axis_inc = 1'b1;
                                state_next   = S_GAP;
                            end
                            AXIS_Y:
                            begin
                                cmd.store_y  = 1'b1;
                                cmd.axis_inc = 1'b1;
                                state_next   = S_GAP;
                            end
                            default:
                            begin
                                cmd.calc_start = 1'b1;
                                cmd.axis_clr   = 1'b1;
                                state_next     = S_CALC;
                            end
                        endcase
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                    end
                end
            end
            S_GAP:
            begin
                if (tick)
                begin
                    if (stat.phase_done)
                    begin
                        cmd.begin_txn = 1'b1;
                        state_next    = S_CMD_LOW;
                    end
                    else
                    begin
                        cmd.tick_inc = 1'b1;
                    end
                end
            end
            S_CALC:
            begin
                // The result word waits until the output register can take it.
                if (stat.div_done && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                if (tick)
                begin
                    cmd.idle_fix = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        flags.calc_active = (state_reg == S_CALC);
        flags.hold_word   = cmd.calc_start;
        flags.emit_result = (state_reg == S_CALC) && stat.div_done && out_free;
        flags.busy_next   = (state_next != S_IDLE) && (state_next != S_CALC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/tpsr_dpath.sv =====
// Datapath of the touch panel SPI readout: timers, shifter, pins, divider, scaling.
// Depends on tpsr_pkg; acts on commands from tpsr_ctrl and on configuration writes.
module tpsr_dpath
    import tpsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       serial_data_out,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output pins_t      pins_next,
    output res_t       res
);

    logic [7:0] half_reg;
    logic [7:0] tick_reg;
    logic [7:0] tick_next;
    logic [3:0] bit_reg;
    logic [3:0] bit_next;
    logic [8:0] samp_reg;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;
    logic [1:0] axis_eff;
    logic [7:0] raw_x_reg;
    logic [7:0] raw_y_reg;
    logic [7:0] z_reg;
    logic [7:0] rem_reg;
    logic [8:0] dq_reg;
    logic [3:0] div_cnt_reg;
    pins_t      pins_reg;

    logic [7:0] half_eff;
    logic [8:0] trial;
    logic       q_bit;
    logic [7:0] code;

    // A half period of zero behaves as one tick.
    assign half_eff = (half_reg == 8'd0) ? 8'd1 : half_reg;

    always_comb
    begin
        stat.phase_done = ({1'b0, tick_reg} + 9'd1) >= {1'b0, half_eff};
        stat.bit_zero   = (bit_reg == 4'd0);
        stat.bits_full  = (bit_reg >= READ_BITS);
        stat.axis       = axis_reg;
        stat.div_done   = (div_cnt_reg == 4'd0);
    end

    always_comb
    begin
        tick_next = tick_reg;
        if (cmd.tick_clr || cmd.begin_txn || cmd.idle_fix)
        begin
            tick_next = 8'd0;
        end
        else if (cmd.tick_inc)
        begin
            tick_next = tick_reg + 8'd1;
        end

        bit_next = bit_reg;
        if (cmd.begin_txn)
        begin
            bit_next = CMD_MSB;
        end
        else if (cmd.bit_dec)
        begin
            bit_next = bit_reg - 4'd1;
        end
        else if (cmd.sample)
        begin
            bit_next = bit_reg + 4'd1;
        end

        axis_eff  = cmd.axis_clr ? AXIS_X : axis_reg;
        axis_next = cmd.axis_inc ? (axis_reg + 2'd1) : axis_eff;
        code      = cmd_code(axis_eff);

        pins_next = pins_reg;
        if (cmd.begin_txn)
        begin
            pins_next.cs_n = 1'b0;
        end
        if (cmd.cs_hi || cmd.idle_fix)
        begin
            pins_next.cs_n = 1'b1;
        end
        if (cmd.begin_txn || cmd.clk_lo || cmd.idle_fix)
        begin
            pins_next.sclk = 1'b0;
        end
        if (cmd.clk_hi)
        begin
            pins_next.sclk = 1'b1;
        end
        if (cmd.begin_txn || cmd.bit_dec)
        begin
            pins_next.sdi = code[bit_next[2:0]];
        end
    end

    // One restoring step of 256 / z per cycle.
    assign trial = {rem_reg, dq_reg[8]};
    assign q_bit = (trial >= {1'b0, z_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= HALF_RESET;
            tick_reg    <= 8'd0;
            bit_reg     <= 4'd0;
            samp_reg    <= 9'd0;
            axis_reg    <= AXIS_X;
            raw_x_reg   <= 8'd0;
            raw_y_reg   <= 8'd0;
            div_cnt_reg <= 4'd0;
            pins_reg    <= '{cs_n: 1'b1, sclk: 1'b0, sdi: 1'b0};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                half_reg <= cfg_wr_data;
            end
            tick_reg <= tick_next;
            bit_reg  <= bit_next;
            axis_reg <= axis_next;
            pins_reg <= pins_next;
            if (cmd.shreg_clr)
            begin
                samp_reg <= 9'd0;
            end
            else if (cmd.sample)
            begin
                samp_reg <= {samp_reg[7:0], serial_data_out};
            end
            if (cmd.store_x)
            begin
                raw_x_reg <= samp_reg[7:0];
            end
            if (cmd.store_y)
            begin
                raw_y_reg <= samp_reg[7:0];
            end
            if (cmd.calc_start)
            begin
                div_cnt_reg <= DIV_STEPS;
            end
            else if (div_cnt_reg != 4'd0)
            begin
                div_cnt_reg <= div_cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_start)
        begin
            z_reg   <= samp_reg[7:0];
            rem_reg <= 8'd0;
            dq_reg  <= DIVIDEND;
        end
        else if (div_cnt_reg != 4'd0)
        begin
            rem_reg <= q_bit ? 8'(trial - {1'b0, z_reg}) : trial[7:0];
            dq_reg  <= {dq_reg[7:0], q_bit};
        end
    end

    // Result scaling, read by the output stage once the divider has finished.
    logic [19:0] y_prod;
    logic [8:0]  y_third;
    logic [8:0]  y_scaled;
    logic [7:0]  x_adj;
    logic [8:0]  z_term;
    logic [16:0] p_prod;

    always_comb
    begin
        res.x_pos = X_MAX - ((raw_x_reg > X_MAX) ? X_MAX : raw_x_reg);

        // floor(4y / 3) through a reciprocal; exact for every 8-bit y.
        y_prod  = {10'd0, raw_y_reg, 2'b00} * RECIP3;
        y_third = y_prod[RECIP3_SHIFT +: 9];
        if (y_third < Y_OFFSET)
        begin
            y_scaled = 9'd0;
        end
        else if ((y_third - Y_OFFSET) > Y_MAX)
        begin
            y_scaled = Y_MAX;
        end
        else
        begin
            y_scaled = y_third - Y_OFFSET;
        end
        res.y_pos = Y_MAX - y_scaled;

        // 255 * x / 256 is x - 1 for nonzero x.
        x_adj  = (raw_x_reg == 8'd0) ? 8'd0 : (raw_x_reg - 8'd1);
        z_term = dq_reg - 9'd1;
        p_prod = {9'd0, x_adj} * {8'd0, z_term};

        if (z_reg == 8'd0)
        begin
            res.p_inv    = 1'b1;
            res.pressure = 17'sd0;
        end
        else
        begin
            res.p_inv    = 1'b0;
            res.pressure = $signed(p_prod - P_BIAS);
        end
    end

endmodule

// ===== hdl/touch_panel_spi_readout.sv =====
// Top level of the touch panel SPI readout: output word register and handshakes.
// Depends on tpsr_pkg, tpsr_ctrl and tpsr_dpath.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+---------------------------------------------
//  input    | in        | in_valid/in_stall   | start_req, serial_data_out
//  output   | out       | out_valid/out_stall | pins, busy_res, result_valid, x/y, pressure
//  config   | in        | cfg_wr_en           | cfg_wr_data (half_period_ticks)
//
// Each accepted input word is one tick of the serial sequencer and yields one output word,
// loaded into the output register at the same edge but for the Z completion tick; a word
// can enter every cycle while the input is not stalled. At the end of the Z transaction
// the input stalls while the restoring divider forms 256 / z one quotient bit per cycle;
// the result word loads once the divider is done, or later while the word ahead is held up.
// Reset is asynchronous and active low; it leaves the sequencer idle with chip select high.
// A new input word is taken while the output register is empty or being emptied.
module touch_panel_spi_readout
    import tpsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               start_req,
    input  logic               serial_data_out,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               chip_select_n,
    output logic               serial_clock,
    output logic               serial_data_in,
    output logic               busy_res,
    output logic               result_valid,
    output logic [7:0]         x_position,
    output logic [8:0]         y_position,
    output logic signed [16:0] pressure,
    output logic               pressure_invalid
);

    dp_cmd_t    cmd;
    dp_stat_t   stat;
    ctrl_flag_t flags;
    pins_t      pins_next;
    res_t       res;

    logic tick;
    logic load;
    logic out_free;

    logic               out_valid_reg;
    pins_t              pins_out_reg;
    logic               busy_reg;
    logic               result_valid_reg;
    logic [7:0]         x_reg;
    logic [8:0]         y_reg;
    logic signed [16:0] pressure_reg;
    logic               p_inv_reg;

    // The output register can take a word when it is empty or its word leaves now.
    assign out_free = !(out_valid_reg && out_stall);

    // The input waits while the divider runs or while the output word is held up.
    assign in_stall = flags.calc_active || !out_free;
    assign tick     = in_valid && !in_stall;

    // Every tick gives a word, except the completion tick whose word follows the divider.
    assign load = (tick && !flags.hold_word) || flags.emit_result;

    tpsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .start_req (start_req),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd),
        .flags     (flags)
    );

    tpsr_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .serial_data_out (serial_data_out),
        .cmd             (cmd),
        .stat            (stat),
        .pins_next       (pins_next),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result fields read as zero on every word that carries no result.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pins_out_reg     <= pins_next;
            busy_reg         <= flags.busy_next;
            result_valid_reg <= flags.emit_result;
            if (flags.emit_result)
            begin
                x_reg        <= res.x_pos;
                y_reg        <= res.y_pos;
                pressure_reg <= res.pressure;
                p_inv_reg    <= res.p_inv;
            end
            else
            begin
                x_reg        <= 8'd0;
                y_reg        <= 9'd0;
                pressure_reg <= 17'sd0;
                p_inv_reg    <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign chip_select_n    = pins_out_reg.cs_n;
    assign serial_clock     = pins_out_reg.sclk;
    assign serial_data_in   = pins_out_reg.sdi;
    assign busy_res         = busy_reg;
    assign result_valid     = result_valid_reg;
    assign x_position       = x_reg;
    assign y_position       = y_reg;
    assign pressure         = pressure_reg;
    assign pressure_invalid = p_inv_reg;

endmodule

// ===== hdl/tpsr_checker.sv =====
// Port-level checks for the touch panel SPI readout, bound to the top level.
// Depends only on the ports of touch_panel_spi_readout.
module tpsr_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               chip_select_n,
    input logic               serial_clock,
    input logic               serial_data_in,
    input logic               busy_res,
    input logic               result_valid,
    input logic [7:0]         x_position,
    input logic [8:0]         y_position,
    input logic signed [16:0] pressure,
    input logic               pressure_invalid
);

    // A result word closes the sequence: chip select is back high and busy has dropped.
    a_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_valid |-> !busy_res && chip_select_n)
        else $error("result word while a transaction is still open");

    // Words without a result carry zero result fields.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !result_valid |->
            x_position == 8'd0 && y_position == 9'd0 && pressure == 17'sd0 &&
            !pressure_invalid)
        else $error("result fields set on a word without a result");

    // A zero pressure reading forces the estimate to zero.
    a_zero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pressure_invalid |-> result_valid && pressure == 17'sd0)
        else $error("invalid pressure reported with a nonzero estimate");

    // Whenever the sequencer is idle the bus rests with chip select high and the clock low.
    a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> chip_select_n && !serial_clock)
        else $error("bus not at rest while idle");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_valid) &&
            $stable(x_position) && $stable(y_position) && $stable(pressure) &&
            $stable(chip_select_n) && $stable(serial_clock) &&
            $stable(serial_data_in))
        else $error("stalled output word changed");

endmodule

bind touch_panel_spi_readout tpsr_checker u_tpsr_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for touch_panel_spi_readout: drives sequencer ticks with random
// gaps, predicts every output word in-line and compares it field by field.
// Needs only tpsr_pkg and the RTL.
module tb
    import tpsr_pkg::*;
();

    // Sequencer phases of the predictor. One tick moves at most one phase forward.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CMD_LOW,
        SEQ_CMD_HIGH,
        SEQ_RD_LOW,
        SEQ_RD_HIGH,
        SEQ_TAIL,
        SEQ_GAP
    } seq_phase_t;

    // Everything the sequencer remembers from one tick to the next.
    typedef struct packed {
        seq_phase_t  st;
        logic [7:0]  tick;
        logic [3:0]  bits;
        logic [8:0]  sh;
        logic [1:0]  axis;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic        cs_n;
        logic        sclk;
        logic        sdi;
    } seq_state_t;

    // One output word: pin levels, status and, on the completion tick, the report.
    typedef struct packed {
        logic        cs_n;
        logic        sclk;
        logic        sdi;
        logic        busy;
        logic        done;
        logic [7:0]  x;
        logic [8:0]  y;
        logic [16:0] p;
        logic        p_inv;
    } readout_word_t;

    // One input word, i.e. one tick of the sequencer.
    typedef struct packed {
        logic start;
        logic dout;
    } tick_t;

    localparam int NUM_PHASES     = 4;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_SPACING   = 400;
    localparam int WATCHDOG_LIMIT = 2000;

    // Half period, number of completed readouts and start probability for each phase.
    // The first phase runs on the reset value and carries the first directed readout.
    int phase_hp      [NUM_PHASES] = '{4, 0, 1, 2};
    int phase_reports [NUM_PHASES] = '{1, 2, 2, 1};
    int phase_start   [NUM_PHASES] = '{50, 30, 90, 40};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               start_req = 1'b0;
    logic               serial_data_out = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [7:0]         cfg_wr_data = 8'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               chip_select_n;
    logic               serial_clock;
    logic               serial_data_in;
    logic               busy_res;
    logic               result_valid;
    logic [7:0]         x_position;
    logic [8:0]         y_position;
    logic signed [16:0] pressure;
    logic               pressure_invalid;

    // Ticks waiting to be driven, and output words predicted but not yet seen.
    tick_t         pending_ticks [$];
    readout_word_t predicted_words [$];
    // Raw x, y, z bytes (x in the top byte) that the directed readouts return.
    logic [23:0]   forced_raw [$];

    // Two copies of the sequencer: one tracks the accepted words for prediction, the
    // other runs ahead while the stimulus is built so that the data pin can be set
    // exactly at the sampling ticks.
    seq_state_t model_state;
    seq_state_t plan_state;
    logic [7:0] half_period = HALF_RESET;

    logic in_took = 1'b0;
    int   in_gap = 0;
    int   in_calm = 0;
    int   hold_left = 0;
    int   stall_left = 0;
    int   out_calm = 0;
    int   next_hold_at = 300;
    int   quiet_cycles = 0;
    int   mismatches = 0;
    int   out_words = 0;
    int   reports = 0;
    int   zero_press = 0;

    touch_panel_spi_readout u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_req        (start_req),
        .serial_data_out  (serial_data_out),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .chip_select_n    (chip_select_n),
        .serial_clock     (serial_clock),
        .serial_data_in   (serial_data_in),
        .busy_res         (busy_res),
        .result_valid     (result_valid),
        .x_position       (x_position),
        .y_position       (y_position),
        .pressure         (pressure),
        .pressure_invalid (pressure_invalid)
    );

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    // Raw readings biased toward the corners of the scaling: zero and full scale,
    // y values that clamp low or high, x around the 240 limit, and z of one.
    function automatic logic [7:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(0, 11));
            3: return 8'($urandom_range(252, 255));
            4: return 8'($urandom_range(238, 243));
            5: return 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Moves a sequencer copy by one tick and returns the output word that tick produces.
    // Every running phase lasts the half period (zero counts as one tick); the phase
    // action happens on its last tick.
    task automatic advance_sequencer(inout seq_state_t s, input logic [7:0] hp,
                                     input logic start, input logic dout,
                                     output readout_word_t w);
        logic       last_tick;
        logic       open_txn;
        logic       load_bit;
        logic [7:0] code;
        int         ys;
        int         a;
        int         b;
        int         p;
        w = '0;
        open_txn = 1'b0;
        load_bit = 1'b0;
        last_tick = (int'(s.tick) + 1 >= ((hp == 8'd0) ? 1 : int'(hp)));
        if (s.st == SEQ_IDLE)
        begin
            if (start)
            begin
                s.axis = AXIS_X;
                open_txn = 1'b1;
            end
        end
        else if (!last_tick)
        begin
            s.tick = s.tick + 8'd1;
        end
        else
        begin
            s.tick = 8'd0;
            case (s.st)
                SEQ_CMD_LOW:
                begin
                    s.sclk = 1'b1;
                    s.st = SEQ_CMD_HIGH;
                end
                SEQ_CMD_HIGH:
                begin
                    s.sclk = 1'b0;
                    if (s.bits == 4'd0)
                    begin
                        s.sh = 9'd0;
                        s.st = SEQ_RD_LOW;
                    end
                    else
                    begin
                        s.bits = s.bits - 4'd1;
                        load_bit = 1'b1;
                        s.st = SEQ_CMD_LOW;
                    end
                end
                SEQ_RD_LOW:
                begin
                    // The pin is sampled just before the rising read edge.
                    s.sh = {s.sh[7:0], dout};
                    s.bits = s.bits + 4'd1;
                    s.sclk = 1'b1;
                    s.st = SEQ_RD_HIGH;
                end
                SEQ_RD_HIGH:
                begin
                    s.sclk = 1'b0;
                    s.st = (s.bits >= READ_BITS) ? SEQ_TAIL : SEQ_RD_LOW;
                end
                SEQ_TAIL:
                begin
                    s.cs_n = 1'b1;
                    case (s.axis)
                        AXIS_X:
                        begin
                            s.rx = s.sh[7:0];
                            s.axis = AXIS_Y;
                            s.st = SEQ_GAP;
                        end
                        AXIS_Y:
                        begin
                            s.ry = s.sh[7:0];
                            s.axis = AXIS_Z;
                            s.st = SEQ_GAP;
                        end
                        default:
                        begin
                            w.done = 1'b1;
                            w.x = (s.rx > X_MAX) ? 8'd0 : X_MAX - s.rx;
                            ys = (4 * int'(s.ry)) / 3 - int'(Y_OFFSET);
                            if (ys < 0)
                                ys = 0;
                            if (ys > int'(Y_MAX))
                                ys = int'(Y_MAX);
                            w.y = Y_MAX - 9'(ys);
                            if (s.sh[7:0] == 8'd0)
                            begin
                                // No pressure reading: flag it and report zero.
                                w.p_inv = 1'b1;
                            end
                            else
                            begin
                                a = (255 * int'(s.rx)) / 256;
                                b = int'(DIVIDEND) / int'(s.sh[7:0]) - 1;
                                p = a * b - int'(P_BIAS);
                                w.p = p[16:0];
                            end
                            s.axis = AXIS_X;
                            s.st = SEQ_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    // Chip-select gap between two transactions.
                    open_txn = 1'b1;
                end
            endcase
        end
        if (open_txn)
        begin
            s.tick = 8'd0;
            s.bits = CMD_MSB;
            s.cs_n = 1'b0;
            s.sclk = 1'b0;
            s.st = SEQ_CMD_LOW;
            load_bit = 1'b1;
        end
        if (load_bit)
        begin
            case (s.axis)
                AXIS_X:  code = CMD_X;
                AXIS_Y:  code = CMD_Y;
                default: code = CMD_Z;
            endcase
            s.sdi = code[s.bits[2:0]];
        end
        w.cs_n = s.cs_n;
        w.sclk = s.sclk;
        w.sdi = s.sdi;
        w.busy = (s.st != SEQ_IDLE);
    endtask

    // Builds the ticks of one phase until the given number of readouts has completed,
    // then a few idle ticks. Starts while busy are sprinkled in and must be ignored;
    // some of them land on the completion tick. At the eight kept sample points the
    // data pin carries the chosen raw byte MSB first; elsewhere it is random.
    task automatic plan_readouts(input logic [7:0] hp, input int count, input int start_pct);
        int            done;
        int            tail;
        int            idx;
        tick_t         t;
        readout_word_t w;
        logic [23:0]   raw;
        logic [7:0]    plan_x;
        logic [7:0]    plan_y;
        logic [7:0]    plan_z;
        done = 0;
        tail = $urandom_range(1, 4);
        plan_x = 8'd0;
        plan_y = 8'd0;
        plan_z = 8'd0;
        while (done < count || tail > 0)
        begin
            if (done >= count)
            begin
                t.start = 1'b0;
                tail--;
            end
            else if (plan_state.st == SEQ_IDLE)
                t.start = ($urandom_range(0, 99) < start_pct);
            else
                t.start = ($urandom_range(0, 3) == 0);
            if (t.start && plan_state.st == SEQ_IDLE)
            begin
                if (forced_raw.size() != 0)
                    raw = forced_raw.pop_front();
                else
                    raw = {pick_raw(), pick_raw(), pick_raw()};
                {plan_x, plan_y, plan_z} = raw;
            end
            t.dout = 1'($urandom_range(0, 1));
            idx = int'(plan_state.bits) + 1;
            if (plan_state.st == SEQ_RD_LOW && idx >= 2 && idx <= 9)
            begin
                case (plan_state.axis)
                    AXIS_X:  t.dout = plan_x[9 - idx];
                    AXIS_Y:  t.dout = plan_y[9 - idx];
                    default: t.dout = plan_z[9 - idx];
                endcase
            end
            pending_ticks.push_back(t);
            advance_sequencer(plan_state, hp, t.start, t.dout, w);
            if (w.done)
                done++;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Main sequence: reset, then one phase per half-period setting. Between phases the
    // sender pauses until every predicted word has come back, so the block is idle
    // when the register is rewritten.
    initial
    begin
        model_state = '0;
        model_state.cs_n = 1'b1;
        plan_state = model_state;
        // Directed readouts: all-zero bytes with no pressure reading, full scale with
        // the largest pressure, x at its limit with small y and the smallest pressure,
        // x just over the limit with y clamping high, and a zero pressure reading
        // beside ordinary x and y.
        forced_raw.push_back({8'd0, 8'd0, 8'd0});
        forced_raw.push_back({8'd255, 8'd255, 8'd1});
        forced_raw.push_back({8'd240, 8'd11, 8'd255});
        forced_raw.push_back({8'd241, 8'd252, 8'd128});
        forced_raw.push_back({8'd200, 8'd251, 8'd0});
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < NUM_PHASES; i++)
        begin
            if (i > 0)
            begin
                while (pending_ticks.size() != 0 || in_valid || predicted_words.size() != 0)
                    @(negedge clk);
                // The output word leaves together with the block going idle, but give
                // the divider a few spare cycles before touching the register.
                repeat (4) @(negedge clk);
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= 8'(phase_hp[i]);
                @(negedge clk);
                cfg_wr_en <= 1'b0;
                half_period = 8'(phase_hp[i]);
            end
            plan_readouts(8'(phase_hp[i]), phase_reports[i], phase_start[i]);
        end
        while (pending_ticks.size() != 0 || in_valid || predicted_words.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Run checked %0d output words holding %0d position reports (%0d zero pressure)",
                 out_words, reports, zero_press);
        $display("over %0d half-period settings from 0 up to 4, with long output back-pressure.",
                 NUM_PHASES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Tick driver. A word stays on the pins until it is taken; then either the next
    // word follows at once or the valid drops for a random gap.
    always @(negedge clk)
    begin : drive_ticks
        tick_t next_tick;
        if (rst_n && (!in_valid || in_took))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_ticks.size() != 0)
            begin
                next_tick = pending_ticks.pop_front();
                start_req <= next_tick.start;
                serial_data_out <= next_tick.dout;
                in_valid <= 1'b1;
                if (in_calm > 0)
                begin
                    in_calm--;
                    in_gap = 0;
                end
                else
                begin
                    in_gap = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        in_calm = $urandom_range(50, 300);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure. Every few hundred words the receiver holds off for a long
    // stretch so that the output register fills and the input side has to stall.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_words >= next_hold_at)
            begin
                hold_left = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_SPACING;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_calm > 0)
                begin
                    out_calm--;
                    stall_left = 0;
                end
                else
                begin
                    stall_left = pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        out_calm = $urandom_range(50, 300);
                end
            end
        end
    end

    // Prediction on every accepted tick, and comparison of every accepted output word
    // against the oldest prediction.
    always @(posedge clk)
    begin : predict_and_check
        readout_word_t w;
        readout_word_t want;
        if (rst_n)
        begin
            in_took <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                advance_sequencer(model_state, half_period, start_req, serial_data_out, w);
                predicted_words.push_back(w);
            end
            if (out_valid && !out_stall)
            begin
                out_words++;
                if (predicted_words.size() == 0)
                begin
                    $error("output word arrived with no prediction pending");
                    mismatches++;
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (want.done)
                        reports++;
                    if (want.p_inv)
                        zero_press++;
                    check_field("chip_select_n", want.cs_n, chip_select_n);
                    check_field("serial_clock", want.sclk, serial_clock);
                    check_field("serial_data_in", want.sdi, serial_data_in);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("result_valid", want.done, result_valid);
                    check_field("x_position", want.x, x_position);
                    check_field("y_position", want.y, y_position);
                    check_field("pressure", $signed(want.p), pressure);
                    check_field("pressure_invalid", want.p_inv, pressure_invalid);
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule

// ===== filelist.f =====
hdl/tpsr_pkg.sv
hdl/tpsr_ctrl.sv
hdl/tpsr_dpath.sv
hdl/touch_panel_spi_readout.sv
hdl/tpsr_checker.sv
verif/tb.sv
